### rtl/wesch_pkg.sv
// Shared types and constants for the weekly event schedule table.
package wesch_pkg;

    localparam logic [10:0] MinPerHour = 11'd60;
    localparam logic [10:0] MinPerDay  = 11'd1440;
    localparam logic [11:0] NoTime     = 12'd3000;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_NEXT   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  start_hour;
        logic [5:0]  start_min;
        logic [10:0] duration;
        logic [6:0]  day_mask;
        logic [8:0]  prior_day;
        logic [4:0]  position;
        logic [4:0]  now_hour;
        logic [5:0]  now_min;
        logic [2:0]  week_day;
        logic [8:0]  year_day;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_index;
        logic        started;
        logic [10:0] minutes_left;
    } rsp_t;

    typedef struct packed {
        logic [10:0] start;
        logic [10:0] length;
        logic [6:0]  mask;
        logic [8:0]  fired;
    } entry_t;

endpackage

### rtl/wesch_cmd_if.sv
// Request channel carrying one schedule command.
interface wesch_cmd_if;
    wesch_pkg::cmd_t data;
    logic            valid;
    logic            ready;

    modport source (output data, output valid, input ready);
    modport sink   (input data, input valid, output ready);
endinterface

### rtl/wesch_rsp_if.sv
// Response channel carrying one schedule result.
interface wesch_rsp_if;
    wesch_pkg::rsp_t data;
    logic            valid;
    logic            ready;

    modport source (output data, output valid, input ready);
    modport sink   (input data, input valid, output ready);
endinterface

### rtl/weekly_event_schedule_table.sv
// Top level of the weekly event schedule table.
//
// cmd takes one request (insert, delete, find current, time to next);
// rsp returns exactly one result per request. Each request runs alone: cmd
// is ready only when the sequencer is idle. The table sits in one memory
// with a registered read port, so every visited entry is first addressed
// (S_RD) and then evaluated (S_EV). An insert on a full table and a delete
// on a bad position go straight to the result; find stops at the first hit;
// time to next searches tomorrow only when no entry remains for today.
// The result is held in an output register; a new request is accepted while
// it waits, and the sequencer holds its next result until rsp is free.
// Reset empties the table (entry count zero) and drops any pending result;
// entry contents are not cleared.
module weekly_event_schedule_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    wesch_cmd_if.sink   cmd,
    wesch_rsp_if.source rsp
);
    import wesch_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_RD    = 5'b00100,
        S_EV    = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        M_INS_SCAN,
        M_INS_SHIFT,
        M_DEL,
        M_FIND,
        M_NEXT1,
        M_NEXT2
    } mode_t;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] at_reg, at_next;
    logic [CW-1:0] which_reg, which_next;
    logic [11:0] best_reg, best_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_data_reg, out_data_next;
    rsp_t        res_reg, res_next;

    logic [1:0]  kind_reg, kind_next;
    logic [10:0] st_reg, st_next;
    logic [10:0] dur_reg, dur_next;
    logic [6:0]  mask_reg, mask_next;
    logic [8:0]  pday_reg, pday_next;
    logic [4:0]  pos_reg, pos_next;
    logic [10:0] now_reg, now_next;
    logic [2:0]  wd_reg, wd_next;
    logic [8:0]  yday_reg, yday_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;

    logic [6:0]  today, tomorrow;
    logic [11:0] new_end, rd_end, cand2;
    logic [10:0] to_mid;
    logic        hit_now, hit_next;
    logic        pos_bad;
    rsp_t        next_res;

    wesch_store #(.AW(AW), .DEPTH(TABLE_DEPTH)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign today    = 7'(8'd1 << wd_reg);
    assign tomorrow = (wd_reg >= 3'd6) ? 7'd1 : 7'(8'd1 << (4'(wd_reg) + 4'd1));
    assign new_end  = 12'(st_reg) + 12'(dur_reg);
    assign rd_end   = 12'(mem_rdata.start) + 12'(mem_rdata.length);
    assign to_mid   = (now_reg >= MinPerDay) ? 11'd0 : (MinPerDay - now_reg);
    assign cand2    = 12'(mem_rdata.start) + 12'(to_mid);
    assign hit_now  = (now_reg >= mem_rdata.start) && (12'(now_reg) < rd_end)
                      && ((mem_rdata.mask & today) != 7'd0);
    assign hit_next = (mem_rdata.fired != yday_reg) && (mem_rdata.start > now_reg)
                      && ((mem_rdata.mask & today) != 7'd0);
    assign pos_bad  = (pos_reg == 5'd0) || (32'(pos_reg) > 32'(count_reg));

    always_comb
    begin
        next_res.status       = (which_reg != '0) ? ST_OK : ST_NONE;
        next_res.entry_index  = 5'(which_reg);
        next_res.started      = 1'b0;
        next_res.minutes_left = (best_reg > 12'(MinPerDay)) ? MinPerDay : best_reg[10:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        at_next        = at_reg;
        which_next     = which_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        kind_next      = kind_reg;
        st_next        = st_reg;
        dur_next       = dur_reg;
        mask_next      = mask_reg;
        pday_next      = pday_reg;
        pos_next       = pos_reg;
        now_next       = now_reg;
        wd_next        = wd_reg;
        yday_next      = yday_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[AW-1:0];
        mem_wdata      = mem_rdata;
        mem_raddr      = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.data.kind;
                    st_next    = 11'(cmd.data.start_hour * MinPerHour) + 11'(cmd.data.start_min);
                    dur_next   = cmd.data.duration;
                    mask_next  = cmd.data.day_mask;
                    pday_next  = cmd.data.prior_day;
                    pos_next   = cmd.data.position;
                    now_next   = 11'(cmd.data.now_hour * MinPerHour) + 11'(cmd.data.now_min);
                    wd_next    = cmd.data.week_day;
                    yday_next  = cmd.data.year_day;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_next   = '0;
                ptr_next   = '0;
                best_next  = NoTime;
                which_next = '0;
                state_next = S_RD;
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (32'(count_reg) >= TABLE_DEPTH)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mode_next = M_INS_SCAN;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (pos_bad)
                        begin
                            res_next.status = ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ptr_next  = CW'(pos_reg - 5'd1);
                            mode_next = M_DEL;
                        end
                    end
                    KIND_FIND: mode_next = M_FIND;
                    default:   mode_next = M_NEXT1;
                endcase
            end
            S_RD:
            begin
                state_next = S_EV;
                case (mode_reg)
                    M_INS_SCAN:
                    begin
                        if (ptr_reg == count_reg)
                        begin
                            at_next    = count_reg;
                            mode_next  = M_INS_SHIFT;
                            state_next = S_RD;
                        end
                    end
                    M_INS_SHIFT:
                    begin
                        mem_raddr = AW'(ptr_reg - CW'(1));
                        if (ptr_reg == at_reg)
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = at_reg[AW-1:0];
                            mem_wdata            = '{st_reg, dur_reg, mask_reg, pday_reg};
                            count_next           = count_reg + CW'(1);
                            res_next.status      = ST_OK;
                            res_next.entry_index = 5'(32'(at_reg) + 1);
                            state_next           = S_DONE;
                        end
                    end
                    M_DEL:
                    begin
                        mem_raddr = AW'(ptr_reg + CW'(1));
                        if ((ptr_reg + CW'(1)) >= count_reg)
                        begin
                            count_next      = count_reg - CW'(1);
                            res_next.status = ST_OK;
                            state_next      = S_DONE;
                        end
                    end
                    M_FIND:
                    begin
                        if (ptr_reg == count_reg)
                        begin
                            res_next.status = ST_NONE;
                            state_next      = S_DONE;
                        end
                    end
                    M_NEXT1:
                    begin
                        if (ptr_reg == count_reg)
                        begin
                            if (best_reg > 12'(MinPerDay))
                            begin
                                ptr_next   = '0;
                                mode_next  = M_NEXT2;
                                state_next = S_RD;
                            end
                            else
                            begin
                                res_next   = next_res;
                                state_next = S_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        if (ptr_reg == count_reg)
                        begin
                            res_next   = next_res;
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_EV:
            begin
                state_next = S_RD;
                case (mode_reg)
                    M_INS_SCAN:
                    begin
                        if (new_end <= rd_end)
                        begin
                            at_next   = ptr_reg;
                            ptr_next  = count_reg;
                            mode_next = M_INS_SHIFT;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + CW'(1);
                        end
                    end
                    M_INS_SHIFT:
                    begin
                        mem_we   = 1'b1;
                        ptr_next = ptr_reg - CW'(1);
                    end
                    M_DEL:
                    begin
                        mem_we   = 1'b1;
                        ptr_next = ptr_reg + CW'(1);
                    end
                    M_FIND:
                    begin
                        if (hit_now)
                        begin
                            if (mem_rdata.fired != yday_reg)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.fired = yday_reg;
                                res_next.started = 1'b1;
                            end
                            res_next.status      = ST_OK;
                            res_next.entry_index = 5'(32'(ptr_reg) + 1);
                            state_next           = S_DONE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + CW'(1);
                        end
                    end
                    M_NEXT1:
                    begin
                        if (hit_next && (best_reg > 12'(mem_rdata.start - now_reg)))
                        begin
                            best_next  = 12'(mem_rdata.start - now_reg);
                            which_next = ptr_reg + CW'(1);
                        end
                        ptr_next = ptr_reg + CW'(1);
                    end
                    default:
                    begin
                        if (((mem_rdata.mask & tomorrow) != 7'd0) && (best_reg > cand2))
                        begin
                            best_next  = cand2;
                            which_next = ptr_reg + CW'(1);
                        end
                        ptr_next = ptr_reg + CW'(1);
                    end
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_FIND;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        at_reg       <= at_next;
        which_reg    <= which_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        kind_reg     <= kind_next;
        st_reg       <= st_next;
        dur_reg      <= dur_next;
        mask_reg     <= mask_next;
        pday_reg     <= pday_next;
        pos_reg      <= pos_next;
        now_reg      <= now_next;
        wd_reg       <= wd_next;
        yday_reg     <= yday_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TABLE_DEPTH)
        else $error("entry count beyond table depth");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_started_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.started) |->
        (out_data_reg.status == ST_OK && out_data_reg.entry_index != 5'd0))
        else $error("started flagged without a matched entry");

endmodule

### rtl/wesch_store.sv
// Event table memory: one write port, one registered read port.
module wesch_store #(
    parameter int AW    = 4,
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  wesch_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output wesch_pkg::entry_t rdata
);
    import wesch_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
